// ----- sv/pcgp_pkg.sv -----
// Shared types, constants and saturating helpers for the goal potential block.
`default_nettype none

package pcgp_pkg;

	// Intermediate values are clamped to +/-(2^62 - 1) and held as 63-bit signed.
	localparam logic [62:0] WIDE_LIM = 63'h3FFF_FFFF_FFFF_FFFF;

	// Divider: quotient bits resolved per stage and number of stages.
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = 9;
	localparam int QUO_BITS  = DIV_BITS * DIV_STEPS;

	localparam int CFG_IDX_W = 4;

	// Register reset values.
	localparam logic [30:0] WELL_RADIUS_RST  = 31'd65536;
	localparam logic [30:0] INNER_RADIUS_RST = 31'd19661;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic signed [62:0] S32_MAX_W = 63'sd2147483647;
	localparam logic signed [62:0] S32_MIN_W = -63'sd2147483648;

	typedef enum logic [1:0] {
		REGION_INNER  = 2'd0,
		REGION_OUTER  = 2'd1,
		REGION_BEYOND = 2'd2
	} region_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WELL_RADIUS  = 4'd0,
		CFG_INNER_RADIUS = 4'd1,
		CFG_INNER_CUBIC  = 4'd2,
		CFG_INNER_SQUARE = 4'd3,
		CFG_OUTER_CUBIC  = 4'd4,
		CFG_OUTER_SQUARE = 4'd5,
		CFG_OUTER_LINEAR = 4'd6,
		CFG_OUTER_OFFSET = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [62:0] val;
		logic               ov;
	} wide_t;

	typedef struct packed {
		logic [31:0] val;
		logic        ov;
	} sat_t;

	// Per-item control that travels with the data.
	typedef struct packed {
		logic [31:0] dlen;
		logic        inner;
		logic        beyond;
		logic        ov;
	} meta_t;

	// Divider stage contents.
	typedef struct packed {
		meta_t               meta;
		logic [31:0]         rem;
		logic [QUO_BITS-1:0] xq;
		logic [31:0]         pot;
		logic [31:0]         gin;
		logic                gin_ov;
		logic                neg;
		logic                big;
	} div_t;

	typedef struct packed {
		logic [31:0] potential;
		logic [31:0] scaled_gradient;
		region_t     region;
		logic        overflow;
	} res_t;

	// Sum of two clamped values, clamped again.
	function automatic wide_t sadd(input logic signed [62:0] a, input logic signed [62:0] b);
		logic signed [63:0] s;
		logic signed [63:0] lim;
		wide_t r;
		lim = $signed({1'b0, WIDE_LIM});
		s = {a[62], a} + {b[62], b};
		r.ov = 1'b0;
		r.val = s[62:0];
		if (s > lim) begin
			r.ov = 1'b1;
			r.val = $signed(WIDE_LIM);
		end else if (s < -lim) begin
			r.ov = 1'b1;
			r.val = -$signed(WIDE_LIM);
		end
		return r;
	endfunction

	// Saturation to the signed 32-bit range.
	function automatic sat_t sat32(input logic signed [62:0] v);
		sat_t r;
		r.ov = 1'b0;
		r.val = v[31:0];
		if (v > S32_MAX_W) begin
			r.ov = 1'b1;
			r.val = S32_MAX;
		end else if (v < S32_MIN_W) begin
			r.ov = 1'b1;
			r.val = S32_MIN;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/piecewise_cubic_goal_potential.sv -----
// Piecewise cubic goal potential: value and scaled gradient from a distance.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------------
//  input    | in_valid / in_ready         | distance
//  result   | out_valid / out_ready       | potential, scaled_gradient, region, overflow
//  config   | cfg_valid / cfg_ready (=1)  | cfg_index, cfg_data
//
// One item is accepted per cycle while the skid entry is empty; the result reaches
// the ports after passing 20 register stages.
// The depth is set by the nine-stage divider (four quotient bits per stage)
// behind eight stages of multiply, round and clamp.
// Reset clears the valid bits and loads the register reset values; no clearing pass.
// A stalled result is held in the output register and one skid entry; the
// pipeline freezes only while the skid entry is full.
`default_nettype none

module piecewise_cubic_goal_potential #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    distance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    potential,
	output logic [31:0]                    scaled_gradient,
	output logic [1:0]                     region,
	output logic                           overflow,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int D2W  = 64 - FRAC_BITS;
	localparam int D2HW = D2W - 32;
	localparam int D3FW = 97 - FRAC_BITS;
	localparam int MAGW = 97;
	localparam int XW   = 62 + FRAC_BITS;
	localparam int XHW  = XW - pcgp_pkg::QUO_BITS;
	localparam int QW1  = pcgp_pkg::QUO_BITS + 1;
	localparam int NDS  = pcgp_pkg::DIV_STEPS;
	localparam int NPR  = 5;
	localparam int PR_VCUBE = 0;
	localparam int PR_VSQ   = 1;
	localparam int PR_VLIN  = 2;
	localparam int PR_GA    = 3;
	localparam int PR_GB    = 4;
	localparam logic [MAGW-1:0] ROUND = (MAGW'(1) << FRAC_BITS) - MAGW'(1);
	localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

	// Magnitude of a signed 32-bit coefficient.
	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	// Item control with further overflow merged in.
	function automatic pcgp_pkg::meta_t meta_ov(input pcgp_pkg::meta_t m, input logic ov);
		pcgp_pkg::meta_t r;
		r = m;
		r.ov = m.ov | ov;
		return r;
	endfunction

	// Product magnitude to signed fixed point: round toward minus infinity, clamp.
	function automatic pcgp_pkg::wide_t mul_fin(input logic [MAGW-1:0] mag, input logic neg);
		logic [MAGW-1:0] rnd;
		logic [MAGW-1:0] sh;
		logic [61:0] m;
		pcgp_pkg::wide_t r;
		rnd = mag + (neg ? ROUND : '0);
		sh = rnd >> FRAC_BITS;
		r.ov = (sh > MAGW'(pcgp_pkg::WIDE_LIM));
		m = r.ov ? pcgp_pkg::WIDE_LIM[61:0] : sh[61:0];
		r.val = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		return r;
	endfunction

	// Restoring division, a few quotient bits per call.
	function automatic pcgp_pkg::div_t div_step(input pcgp_pkg::div_t a);
		logic [32:0] r;
		pcgp_pkg::div_t b;
		b = a;
		for (int i = 0; i < pcgp_pkg::DIV_BITS; i++) begin
			r = {b.rem, b.xq[pcgp_pkg::QUO_BITS-1]};
			b.xq = {b.xq[pcgp_pkg::QUO_BITS-2:0], 1'b0};
			if (r >= {1'b0, b.meta.dlen}) begin
				b.rem = 32'(r - {1'b0, b.meta.dlen});
				b.xq[0] = 1'b1;
			end else begin
				b.rem = r[31:0];
			end
		end
		return b;
	endfunction

	// Configuration registers.
	logic [30:0] well_q, inner_r_q;
	logic [31:0] a1_q, b1_q, a2_q, b2_q, c2_q, e2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			well_q    <= pcgp_pkg::WELL_RADIUS_RST;
			inner_r_q <= pcgp_pkg::INNER_RADIUS_RST;
			a1_q      <= '0;
			b1_q      <= '0;
			a2_q      <= '0;
			b2_q      <= '0;
			c2_q      <= '0;
			e2_q      <= '0;
		end else if (cfg_valid) begin
			unique case (pcgp_pkg::cfg_idx_t'(cfg_index))
				pcgp_pkg::CFG_WELL_RADIUS:  well_q    <= cfg_data[30:0];
				pcgp_pkg::CFG_INNER_RADIUS: inner_r_q <= cfg_data[30:0];
				pcgp_pkg::CFG_INNER_CUBIC:  a1_q      <= cfg_data;
				pcgp_pkg::CFG_INNER_SQUARE: b1_q      <= cfg_data;
				pcgp_pkg::CFG_OUTER_CUBIC:  a2_q      <= cfg_data;
				pcgp_pkg::CFG_OUTER_SQUARE: b2_q      <= cfg_data;
				pcgp_pkg::CFG_OUTER_LINEAR: c2_q      <= cfg_data;
				pcgp_pkg::CFG_OUTER_OFFSET: e2_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline advance: frozen only while the skid entry holds an item.
	logic skid_vld_q, out_vld_q;
	logic run;
	assign run = !skid_vld_q;
	assign in_ready = run;

	// Stage registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s19;
	logic dv_v_s [NDS+1];
	pcgp_pkg::meta_t m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7, m_s8;
	logic [63:0] dd_s1;
	logic [D2W-1:0] d2_s2, d2_s3;
	logic [63:0] pl_s2;
	logic [D2HW+31:0] ph_s2;
	logic [61:0] d3_s3;
	logic [64:0] pl_s4 [NPR];
	logic [62:0] ph_s4 [NPR];
	logic ng_s4 [NPR];
	pcgp_pkg::wide_t pr_s5 [NPR];
	pcgp_pkg::wide_t v1_s6, n1_s6, v2_s7, n2_s7, v3_s8;
	logic signed [62:0] vlin_s6;
	pcgp_pkg::sat_t gin_s8;
	logic [61:0] un_s8;
	logic neg_s8;
	pcgp_pkg::div_t dv_s [NDS+1];
	pcgp_pkg::res_t res_s19;

	// Stage 1: region compares.
	logic beyond_c, inner_c;
	assign beyond_c = distance >= {well_q, 1'b0};
	assign inner_c  = distance < {1'b0, inner_r_q};

	// Stage 3: cube of distance from partial products.
	logic [D3FW-1:0] dsum_c, d3_sh_c;
	logic d3_ov_c;
	assign dsum_c  = (D3FW'(ph_s2) << 32) + D3FW'(pl_s2);
	assign d3_sh_c = dsum_c >> FRAC_BITS;
	assign d3_ov_c = d3_sh_c > D3FW'(pcgp_pkg::WIDE_LIM);

	// Stage 4: coefficient selection and product operands.
	logic [31:0] ca_c, cb_c, cc_c, ma_c, mb_c, mc_c;
	logic [32:0] mg_c [NPR];
	logic [61:0] op_c [NPR];
	logic ng_c [NPR];

	always_comb begin
		ca_c = m_s3.inner ? a1_q : a2_q;
		cb_c = m_s3.inner ? b1_q : b2_q;
		cc_c = m_s3.inner ? 32'd0 : c2_q;
		ma_c = mag32(ca_c);
		mb_c = mag32(cb_c);
		mc_c = mag32(cc_c);
		mg_c[PR_VCUBE] = {1'b0, ma_c};
		op_c[PR_VCUBE] = d3_s3;
		ng_c[PR_VCUBE] = ca_c[31];
		mg_c[PR_VSQ]   = {1'b0, mb_c};
		op_c[PR_VSQ]   = 62'(d2_s3);
		ng_c[PR_VSQ]   = cb_c[31];
		mg_c[PR_VLIN]  = {1'b0, mc_c};
		op_c[PR_VLIN]  = 62'(m_s3.dlen);
		ng_c[PR_VLIN]  = cc_c[31];
		mg_c[PR_GA]    = {1'b0, ma_c} + {ma_c, 1'b0};
		op_c[PR_GA]    = m_s3.inner ? 62'(m_s3.dlen) : 62'(d2_s3);
		ng_c[PR_GA]    = ca_c[31];
		mg_c[PR_GB]    = {mb_c, 1'b0};
		op_c[PR_GB]    = 62'(m_s3.dlen);
		ng_c[PR_GB]    = cb_c[31];
	end

	// Stage 5: round and clamp each product; the inner gradient uses 2*b1 as is.
	pcgp_pkg::wide_t pr_c [NPR];
	logic pr_ov_c;

	always_comb begin
		pr_ov_c = 1'b0;
		for (int i = 0; i < NPR; i++) begin
			pr_c[i] = mul_fin((MAGW'(ph_s4[i]) << 32) + MAGW'(pl_s4[i]), ng_s4[i]);
		end
		if (m_s4.inner) begin
			pr_c[PR_GB].val = $signed({{30{b1_q[31]}}, b1_q, 1'b0});
			pr_c[PR_GB].ov  = 1'b0;
		end
		for (int i = 0; i < NPR; i++) begin
			pr_ov_c = pr_ov_c | pr_c[i].ov;
		end
	end

	// Stages 6 to 8: clamped sums.
	pcgp_pkg::wide_t v1_c, n1_c, v2_c, n2_c, v3_c;
	logic signed [62:0] cterm_c, eterm_c;

	assign v1_c    = pcgp_pkg::sadd(pr_s5[PR_VCUBE].val, pr_s5[PR_VSQ].val);
	assign n1_c    = pcgp_pkg::sadd(pr_s5[PR_GA].val, pr_s5[PR_GB].val);
	assign cterm_c = m_s6.inner ? '0 : $signed({{31{c2_q[31]}}, c2_q});
	assign v2_c    = pcgp_pkg::sadd(v1_s6.val, vlin_s6);
	assign n2_c    = pcgp_pkg::sadd(n1_s6.val, cterm_c);
	assign eterm_c = m_s7.inner ? '0 : $signed({{31{e2_q[31]}}, e2_q});
	assign v3_c    = pcgp_pkg::sadd(v2_s7.val, eterm_c);

	// Stage 9: potential saturation and divider setup.
	pcgp_pkg::sat_t pot_c;
	logic [XW-1:0] x_c;
	pcgp_pkg::div_t dv0_c;

	always_comb begin
		pot_c = pcgp_pkg::sat32(v3_s8.val);
		x_c = {un_s8, {FRAC_BITS{1'b0}}};
		dv0_c.meta     = m_s8;
		dv0_c.meta.ov  = m_s8.ov | pot_c.ov;
		dv0_c.rem      = x_c[pcgp_pkg::QUO_BITS+31:pcgp_pkg::QUO_BITS];
		dv0_c.xq       = x_c[pcgp_pkg::QUO_BITS-1:0];
		dv0_c.pot      = pot_c.val;
		dv0_c.gin      = gin_s8.val;
		dv0_c.gin_ov   = gin_s8.ov;
		dv0_c.neg      = neg_s8;
		dv0_c.big      = x_c[XW-1:pcgp_pkg::QUO_BITS] >= XHW'(m_s8.dlen);
	end

	// Last stage: quotient rounding, saturation and region selection.
	pcgp_pkg::div_t dq;
	logic [QW1-1:0] mq_c;
	pcgp_pkg::res_t res_c;

	always_comb begin
		dq = dv_s[NDS];
		mq_c = {1'b0, dq.xq} + QW1'(dq.neg && (dq.rem != 32'd0));
		res_c.potential = dq.pot;
		res_c.scaled_gradient = '0;
		res_c.region = pcgp_pkg::REGION_OUTER;
		res_c.overflow = dq.meta.ov;
		priority if (dq.meta.beyond) begin
			res_c.potential = ONE_Q;
			res_c.region = pcgp_pkg::REGION_BEYOND;
			res_c.overflow = 1'b0;
		end else if (dq.meta.inner) begin
			res_c.scaled_gradient = dq.gin;
			res_c.region = pcgp_pkg::REGION_INNER;
			res_c.overflow = dq.meta.ov | dq.gin_ov;
		end else if ((dq.meta.dlen == 32'd0) || dq.big) begin
			res_c.scaled_gradient = dq.neg ? pcgp_pkg::S32_MIN : pcgp_pkg::S32_MAX;
			res_c.overflow = 1'b1;
		end else if (!dq.neg) begin
			if (mq_c > QW1'(pcgp_pkg::S32_MAX)) begin
				res_c.scaled_gradient = pcgp_pkg::S32_MAX;
				res_c.overflow = 1'b1;
			end else begin
				res_c.scaled_gradient = mq_c[31:0];
			end
		end else begin
			if (mq_c > QW1'(pcgp_pkg::S32_MIN)) begin
				res_c.scaled_gradient = pcgp_pkg::S32_MIN;
				res_c.overflow = 1'b1;
			end else begin
				res_c.scaled_gradient = 32'd0 - mq_c[31:0];
			end
		end
	end

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s19 <= 1'b0;
			for (int k = 0; k <= NDS; k++) begin
				dv_v_s[k] <= 1'b0;
			end
		end else if (run) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			dv_v_s[0] <= v_s8;
			for (int k = 1; k <= NDS; k++) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
			v_s19 <= dv_v_s[NDS];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (run) begin
			m_s1  <= '{dlen: distance, inner: inner_c, beyond: beyond_c, ov: 1'b0};
			dd_s1 <= distance * distance;

			m_s2  <= m_s1;
			d2_s2 <= dd_s1[63:FRAC_BITS];
			pl_s2 <= dd_s1[FRAC_BITS+31:FRAC_BITS] * m_s1.dlen;
			ph_s2 <= dd_s1[63:FRAC_BITS+32] * m_s1.dlen;

			m_s3    <= meta_ov(m_s2, d3_ov_c);
			d2_s3   <= d2_s2;
			d3_s3   <= d3_ov_c ? pcgp_pkg::WIDE_LIM[61:0] : d3_sh_c[61:0];

			m_s4 <= m_s3;
			for (int i = 0; i < NPR; i++) begin
				pl_s4[i] <= mg_c[i] * op_c[i][31:0];
				ph_s4[i] <= mg_c[i] * op_c[i][61:32];
				ng_s4[i] <= ng_c[i];
			end

			m_s5    <= meta_ov(m_s4, pr_ov_c);
			for (int i = 0; i < NPR; i++) begin
				pr_s5[i] <= pr_c[i];
			end

			m_s6    <= meta_ov(m_s5, v1_c.ov | n1_c.ov);
			v1_s6   <= v1_c;
			n1_s6   <= n1_c;
			vlin_s6 <= pr_s5[PR_VLIN].val;

			m_s7    <= meta_ov(m_s6, v2_c.ov | n2_c.ov);
			v2_s7   <= v2_c;
			n2_s7   <= n2_c;

			m_s8    <= meta_ov(m_s7, v3_c.ov);
			v3_s8   <= v3_c;
			gin_s8  <= pcgp_pkg::sat32(n2_s7.val);
			neg_s8  <= n2_s7.val[62];
			un_s8   <= n2_s7.val[62] ? 62'(-n2_s7.val) : n2_s7.val[61:0];

			dv_s[0] <= dv0_c;
			for (int k = 1; k <= NDS; k++) begin
				dv_s[k] <= div_step(dv_s[k-1]);
			end

			res_s19 <= res_c;
		end
	end

	// Output register with one skid entry.
	pcgp_pkg::res_t out_q, skid_q;
	logic take;
	assign take = out_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || take) begin
			out_vld_q <= v_s19;
		end else if (v_s19) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_vld_q || take) begin
			out_q <= res_s19;
		end else begin
			skid_q <= res_s19;
		end
	end

	assign out_valid       = out_vld_q;
	assign potential       = out_q.potential;
	assign scaled_gradient = out_q.scaled_gradient;
	assign region          = out_q.region;
	assign overflow        = out_q.overflow;

endmodule

`default_nettype wire

// ----- sv/pcgp_checker.sv -----
// Port-level checks for the goal potential block, bound to its top level.
`default_nettype none

module pcgp_checker #(
	parameter int FRAC_BITS = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] potential,
	input wire logic [31:0] scaled_gradient,
	input wire logic [1:0]  region,
	input wire logic        overflow
);

	localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(potential) &&
			$stable(scaled_gradient) && $stable(region) && $stable(overflow))
		else $error("result changed while stalled");

	// At or beyond twice the well radius the result is fixed.
	a_beyond_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (region == pcgp_pkg::REGION_BEYOND) |->
			(potential == ONE_Q) && (scaled_gradient == 32'd0) && !overflow)
		else $error("beyond-region result is not one with zero gradient");

	// Input is refused only behind a result that was held up.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(out_valid && !out_ready))
		else $error("input refused without output backpressure");

endmodule

bind piecewise_cubic_goal_potential pcgp_checker #(.FRAC_BITS(FRAC_BITS)) u_pcgp_checker (.*);

`default_nettype wire

// ----- dv/piecewise_cubic_goal_potential_tb.sv -----
// Testbench for the goal potential block: random and directed distances against a predictor.
`default_nettype none

module piecewise_cubic_goal_potential_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam logic [pcgp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd9;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 258;
	localparam int DRAIN_CYCLES = 40;

	// Scoreboard: holds a copy of the registers and the queue of expected results.
	class potential_scoreboard;
		logic [31:0] regs [8];
		pcgp_pkg::res_t expected_q [$];
		int mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			regs[pcgp_pkg::CFG_WELL_RADIUS] = {1'b0, pcgp_pkg::WELL_RADIUS_RST};
			regs[pcgp_pkg::CFG_INNER_RADIUS] = {1'b0, pcgp_pkg::INNER_RADIUS_RST};
			mismatches = 0;
		endfunction

		function void write_reg(logic [pcgp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == pcgp_pkg::CFG_WELL_RADIUS || idx == pcgp_pkg::CFG_INNER_RADIUS) begin
				regs[idx] = {1'b0, data[30:0]};
			end else if (idx <= pcgp_pkg::CFG_OUTER_OFFSET) begin
				regs[idx] = data;
			end
		endfunction

		// Clamp to the intermediate range of +/-(2^62 - 1).
		function longint clamp_wide(logic signed [127:0] v, ref bit ov);
			logic signed [127:0] lim;
			lim = 128'sh3FFF_FFFF_FFFF_FFFF;
			if (v > lim) begin
				ov = 1'b1;
				return lim[63:0];
			end
			if (v < -lim) begin
				ov = 1'b1;
				return -lim[63:0];
			end
			return v[63:0];
		endfunction

		// Fixed-point product, rounded toward minus infinity.
		function longint mul_fixed(longint a, longint b, ref bit ov);
			logic signed [127:0] pa;
			logic signed [127:0] pb;
			pa = a;
			pb = b;
			return clamp_wide((pa * pb) >>> FRAC, ov);
		endfunction

		function longint add_wide(longint a, longint b, ref bit ov);
			logic signed [127:0] pa;
			logic signed [127:0] pb;
			pa = a;
			pb = b;
			return clamp_wide(pa + pb, ov);
		endfunction

		// floor(n * 2^FRAC / d) for a nonzero divisor.
		function logic signed [127:0] div_fixed(longint n, logic [31:0] d);
			logic signed [127:0] num;
			logic signed [127:0] den;
			logic signed [127:0] q;
			num = n;
			num = num <<< FRAC;
			den = {96'd0, d};
			q = num / den;
			if (num < 0 && (num % den) != 0) q = q - 1;
			return q;
		endfunction

		function logic [31:0] sat_word(logic signed [127:0] v, ref bit ov);
			if (v > 128'sh7FFF_FFFF) begin
				ov = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (v < -128'sh8000_0000) begin
				ov = 1'b1;
				return 32'h8000_0000;
			end
			return v[31:0];
		endfunction

		function pcgp_pkg::res_t predict_potential(logic [31:0] d);
			pcgp_pkg::res_t r;
			bit ov;
			longint sd, sq, cu, val, grad_n, a, b, c, e;
			logic signed [127:0] grad;
			ov = 1'b0;
			if ({1'b0, d} >= {regs[pcgp_pkg::CFG_WELL_RADIUS], 1'b0}) begin
				r.potential = 32'h1 << FRAC;
				r.scaled_gradient = '0;
				r.region = pcgp_pkg::REGION_BEYOND;
				r.overflow = 1'b0;
				return r;
			end
			sd = {32'd0, d};
			sq = mul_fixed(sd, sd, ov);
			cu = mul_fixed(sq, sd, ov);
			if (d < regs[pcgp_pkg::CFG_INNER_RADIUS]) begin
				a = $signed(regs[pcgp_pkg::CFG_INNER_CUBIC]);
				b = $signed(regs[pcgp_pkg::CFG_INNER_SQUARE]);
				r.region = pcgp_pkg::REGION_INNER;
				val = add_wide(mul_fixed(a, cu, ov), mul_fixed(b, sq, ov), ov);
				grad = add_wide(mul_fixed(3 * a, sd, ov), 2 * b, ov);
			end else begin
				a = $signed(regs[pcgp_pkg::CFG_OUTER_CUBIC]);
				b = $signed(regs[pcgp_pkg::CFG_OUTER_SQUARE]);
				c = $signed(regs[pcgp_pkg::CFG_OUTER_LINEAR]);
				e = $signed(regs[pcgp_pkg::CFG_OUTER_OFFSET]);
				r.region = pcgp_pkg::REGION_OUTER;
				val = add_wide(mul_fixed(a, cu, ov), mul_fixed(b, sq, ov), ov);
				val = add_wide(val, mul_fixed(c, sd, ov), ov);
				val = add_wide(val, e, ov);
				grad_n = add_wide(mul_fixed(3 * a, sq, ov), mul_fixed(2 * b, sd, ov), ov);
				grad_n = add_wide(grad_n, c, ov);
				// A zero distance in the outer region saturates by the numerator's sign.
				if (d == 0) begin
					ov = 1'b1;
					grad = (grad_n >= 0) ? 128'sh7FFF_FFFF : -128'sh8000_0000;
				end else begin
					grad = div_fixed(grad_n, d);
				end
			end
			r.potential = sat_word(val, ov);
			r.scaled_gradient = sat_word(grad, ov);
			r.overflow = ov;
			return r;
		endfunction

		function void note_distance(logic [31:0] d);
			expected_q.push_back(predict_potential(d));
		endfunction

		function void check_result(pcgp_pkg::res_t got);
			pcgp_pkg::res_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result pot=%h grad=%h region=%0d ov=%b", $time,
					got.potential, got.scaled_gradient, got.region, got.overflow);
				mismatches++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.potential !== exp_r.potential) begin
				$display("%0t: potential expected %h actual %h", $time,
					exp_r.potential, got.potential);
				mismatches++;
			end
			if (got.scaled_gradient !== exp_r.scaled_gradient) begin
				$display("%0t: scaled_gradient expected %h actual %h", $time,
					exp_r.scaled_gradient, got.scaled_gradient);
				mismatches++;
			end
			if (got.region !== exp_r.region) begin
				$display("%0t: region expected %0d actual %0d", $time,
					exp_r.region, got.region);
				mismatches++;
			end
			if (got.overflow !== exp_r.overflow) begin
				$display("%0t: overflow expected %b actual %b", $time,
					exp_r.overflow, got.overflow);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] distance = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] potential;
	logic [31:0] scaled_gradient;
	logic [1:0] region;
	logic overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pcgp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int idle_pct = 34;
	potential_scoreboard sb = new();

	piecewise_cubic_goal_potential DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.distance(distance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.potential(potential),
		.scaled_gradient(scaled_gradient),
		.region(region),
		.overflow(overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Random backpressure on the result side.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Watch all three channels and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_distance(distance);
			if (out_valid && out_ready) begin
				sb.check_result('{potential, scaled_gradient,
					pcgp_pkg::region_t'(region), overflow});
			end
		end
	end

	task automatic write_reg(logic [pcgp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_distance(logic [31:0] d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		distance <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	// Let every expected result arrive, then allow the pipeline to empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_coeffs(logic [31:0] wr, logic [31:0] ir, logic [31:0] a1,
			logic [31:0] b1, logic [31:0] a2, logic [31:0] b2, logic [31:0] c2, logic [31:0] e2);
		write_reg(pcgp_pkg::CFG_WELL_RADIUS, wr);
		write_reg(pcgp_pkg::CFG_INNER_RADIUS, ir);
		write_reg(pcgp_pkg::CFG_INNER_CUBIC, a1);
		write_reg(pcgp_pkg::CFG_INNER_SQUARE, b1);
		write_reg(pcgp_pkg::CFG_OUTER_CUBIC, a2);
		write_reg(pcgp_pkg::CFG_OUTER_SQUARE, b2);
		write_reg(pcgp_pkg::CFG_OUTER_LINEAR, c2);
		write_reg(pcgp_pkg::CFG_OUTER_OFFSET, e2);
	endtask

	// Pick a distance aimed at one region of the current setting, a small one or a random one.
	function automatic logic [31:0] pick_distance();
		longint unsigned lo, hi, ir, lim;
		ir = sb.regs[pcgp_pkg::CFG_INNER_RADIUS];
		lim = 2 * longint'(sb.regs[pcgp_pkg::CFG_WELL_RADIUS]);
		case ($urandom_range(4))
			0: begin lo = 0; hi = ir; end
			1: begin lo = ir; hi = lim; end
			2: begin lo = lim; hi = 64'hFFFF_FFFF; end
			3: begin lo = 0; hi = 3; end
			default: return $urandom;
		endcase
		if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
		if (hi <= lo) return $urandom;
		return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
	endfunction

	function automatic logic [31:0] small_coeff();
		return $signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF;
	endfunction

	// Main sequence.
	initial begin
		logic [31:0] directed [$];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				// Phase 0 runs on the reset values.
				1: load_coeffs(32'd65536, 32'd19661, small_coeff(), small_coeff(),
					small_coeff(), small_coeff(), small_coeff(), small_coeff());
				2: load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
				3: begin
					// Inner radius of zero lets a zero distance reach the divider.
					load_coeffs($urandom_range(32'h3_0000), 32'd0, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
					write_reg(CFG_UNUSED_IDX, $urandom);
				end
				4: load_coeffs($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
				5: load_coeffs(32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
				default: ;
			endcase
			directed = '{32'd0, 32'd1};
			if (p == 1) begin
				directed = '{32'd0, 32'd1, 32'd19660, 32'd19661, 32'd19662, 32'd32768,
					32'd65536, 32'd131071, 32'd131072, 32'd131073, 32'h7FFF_FFFF,
					32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
			end
			foreach (directed[i]) send_distance(directed[i]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// A long run with no idling on either side.
				idle_pct = (p == 4 && n >= 60 && n < 200) ? 0 : 34;
				send_distance(pick_distance());
			end
			drain();
		end
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Timeout.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
sv/pcgp_pkg.sv
sv/piecewise_cubic_goal_potential.sv
sv/pcgp_checker.sv
dv/piecewise_cubic_goal_potential_tb.sv
